@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the cipher RTL.
// Each macro checks one implication on the rising clock edge while reset is
// released. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/s20_pkg.sv @@
package s20_pkg;

    // Default lane width in bytes; anything above 8 behaves as 8.
    localparam int LANE_BYTES_DEF = 8;

    // Request queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register indexes on the write port.
    localparam logic [2:0] REG_KEY0   = 3'd0;
    localparam logic [2:0] REG_KEY1   = 3'd1;
    localparam logic [2:0] REG_KEY2   = 3'd2;
    localparam logic [2:0] REG_KEY3   = 3'd3;
    localparam logic [2:0] REG_NONCE  = 3'd4;
    localparam logic [2:0] REG_MODE   = 3'd5;
    localparam logic [2:0] REG_ROUNDS = 3'd6;

    // Key modes.
    localparam logic [1:0] MODE_64  = 2'd0;
    localparam logic [1:0] MODE_128 = 2'd1;
    localparam logic [1:0] MODE_256 = 2'd2;

    localparam logic [3:0] ROUNDS_RESET = 4'd5;

    // Constant words of the hash input.
    localparam logic [31:0] SIGMA0  = 32'h61707865;
    localparam logic [31:0] TAU3_32 = 32'h3320646e;
    localparam logic [31:0] TAU3_16 = 32'h3120646e;
    localparam logic [31:0] TAU3_08 = 32'h3020646e;
    localparam logic [31:0] MID_32  = 32'h79622d32;
    localparam logic [31:0] MID_16  = 32'h79622d36;
    localparam logic [31:0] MID_08  = 32'h79622d38;
    localparam logic [31:0] SIGMA3  = 32'h6b206574;

    // Quarter-round rotate amounts.
    localparam int ROT_A = 7;
    localparam int ROT_B = 9;
    localparam int ROT_C = 13;
    localparam int ROT_D = 18;

    typedef logic [31:0] word_t;
    typedef word_t [15:0] state_t;
    typedef word_t [3:0] quad_t;

    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  byte_count;
        logic        message_end;
    } in_req_t;

    typedef struct packed {
        logic [63:0] out_word;
        logic [3:0]  out_count;
        logic        out_last;
    } out_req_t;

    typedef struct packed {
        logic [63:0] key_part_0;
        logic [63:0] key_part_1;
        logic [63:0] key_part_2;
        logic [63:0] key_part_3;
        logic [63:0] nonce_value;
        logic [1:0]  key_mode;
        logic [3:0]  double_rounds;
    } cfg_t;

    // One classified request: byte_count already saturated, base is the
    // first keystream byte of its lane.
    typedef struct packed {
        in_req_t     req;
        logic        new_block;
        logic [5:0]  base;
        logic [63:0] counter;
    } qentry_t;

    typedef struct packed {
        logic nonempty;
        logic full;
    } q_stat_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_ROUND,
        CORE_FINAL
    } core_state_t;

    function automatic word_t rotl(input word_t v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic quad_t quarter(input word_t a, input word_t b,
                                      input word_t c, input word_t d);
        quad_t r;
        r[1] = b ^ rotl(a + d, ROT_A);
        r[2] = c ^ rotl(r[1] + a, ROT_B);
        r[3] = d ^ rotl(r[2] + r[1], ROT_C);
        r[0] = a ^ rotl(r[3] + r[2], ROT_D);
        return r;
    endfunction

    function automatic state_t column_round(input state_t w);
        state_t r;
        quad_t  q0;
        quad_t  q1;
        quad_t  q2;
        quad_t  q3;
        q0 = quarter(w[0], w[4], w[8], w[12]);
        q1 = quarter(w[5], w[9], w[13], w[1]);
        q2 = quarter(w[10], w[14], w[2], w[6]);
        q3 = quarter(w[15], w[3], w[7], w[11]);
        r[0]  = q0[0]; r[4]  = q0[1]; r[8]  = q0[2]; r[12] = q0[3];
        r[5]  = q1[0]; r[9]  = q1[1]; r[13] = q1[2]; r[1]  = q1[3];
        r[10] = q2[0]; r[14] = q2[1]; r[2]  = q2[2]; r[6]  = q2[3];
        r[15] = q3[0]; r[3]  = q3[1]; r[7]  = q3[2]; r[11] = q3[3];
        return r;
    endfunction

    function automatic state_t row_round(input state_t w);
        state_t r;
        quad_t  q0;
        quad_t  q1;
        quad_t  q2;
        quad_t  q3;
        q0 = quarter(w[0], w[1], w[2], w[3]);
        q1 = quarter(w[5], w[6], w[7], w[4]);
        q2 = quarter(w[10], w[11], w[8], w[9]);
        q3 = quarter(w[15], w[12], w[13], w[14]);
        r[0]  = q0[0]; r[1]  = q0[1]; r[2]  = q0[2]; r[3]  = q0[3];
        r[5]  = q1[0]; r[6]  = q1[1]; r[7]  = q1[2]; r[4]  = q1[3];
        r[10] = q2[0]; r[11] = q2[1]; r[8]  = q2[2]; r[9]  = q2[3];
        r[15] = q3[0]; r[12] = q3[1]; r[13] = q3[2]; r[14] = q3[3];
        return r;
    endfunction

endpackage

@@ rtl/s20_front.sv @@
module s20_front #(
    parameter int LANE_BYTES = s20_pkg::LANE_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  s20_pkg::in_req_t  in_req,
    input  s20_pkg::q_stat_t  q_stat,
    output logic              push,
    output s20_pkg::qentry_t  entry
);

    localparam int LANE_MAX  = (LANE_BYTES > 8) ? 8 : LANE_BYTES;
    localparam int LANES     = 64 / LANE_MAX;
    localparam int LAST_BASE = (LANES - 1) * LANE_MAX;

    localparam logic [3:0] LANE_MAX_C  = 4'(LANE_MAX);
    localparam logic [5:0] LANE_STEP   = 6'(LANE_MAX);
    localparam logic [5:0] LAST_BASE_C = 6'(LAST_BASE);

    logic [63:0] counter_reg;
    logic [63:0] counter_next;
    logic [5:0]  base_reg;
    logic [5:0]  base_next;
    logic        new_block;
    logic [3:0]  count_sat;

    assign in_stall  = q_stat.full;
    assign push      = in_valid && !q_stat.full;
    assign new_block = (base_reg == '0);
    assign count_sat = (in_req.byte_count > LANE_MAX_C) ? LANE_MAX_C : in_req.byte_count;

    always_comb
    begin
        entry.req.data_word   = in_req.data_word;
        entry.req.byte_count  = count_sat;
        entry.req.message_end = in_req.message_end;
        entry.new_block       = new_block;
        entry.base            = base_reg;
        entry.counter         = counter_reg;
    end

    // Advance lane offset and block counter; a message end starts over.
    always_comb
    begin
        counter_next = counter_reg;
        base_next    = base_reg;
        if (push)
        begin
            if (new_block)
                counter_next = counter_reg + 64'd1;
            if (base_reg == LAST_BASE_C)
                base_next = '0;
            else
                base_next = base_reg + LANE_STEP;
            if (in_req.message_end)
            begin
                counter_next = '0;
                base_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            base_reg    <= '0;
        end
        else
        begin
            counter_reg <= counter_next;
            base_reg    <= base_next;
        end
    end

endmodule

@@ rtl/s20_queue.sv @@
`include "assert_macros.svh"

module s20_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  s20_pkg::qentry_t  entry,
    input  logic              pop,
    output s20_pkg::qentry_t  head,
    output s20_pkg::q_stat_t  q_stat
);

    localparam int DEPTH  = s20_pkg::QUEUE_DEPTH;
    localparam int PTR_W  = s20_pkg::QPTR_W;
    localparam int CNT_W  = s20_pkg::QCNT_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    s20_pkg::qentry_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign head            = mem_reg[rd_ptr_reg];
    assign q_stat.nonempty = (count_reg != '0);
    assign q_stat.full     = (count_reg == DEPTH_C);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= entry;
    end

    `ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, count_reg <= DEPTH_C)
    `ASSERT_IMPLIES(a_no_pop_empty, clk, rst_n, pop, count_reg != '0)
    `ASSERT_NEXT(a_push_grows, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

@@ rtl/s20_core.sv @@
module s20_core (
    input  logic                clk,
    input  logic                rst_n,
    input  s20_pkg::cfg_t       cfg,
    input  logic                start,
    input  logic [63:0]         counter,
    output s20_pkg::core_stat_t stat,
    output s20_pkg::state_t     ks
);

    s20_pkg::core_state_t state_reg;
    s20_pkg::core_state_t state_next;

    s20_pkg::state_t init_reg;
    s20_pkg::state_t work_reg;
    s20_pkg::state_t ks_reg;
    s20_pkg::state_t s_init;
    s20_pkg::state_t round_out;

    logic [4:0]  half_reg;
    logic [4:0]  last_half;
    logic [63:0] ka;
    logic [63:0] kb;
    logic [63:0] kc;
    logic [63:0] kd;
    logic [31:0] tau;
    logic [31:0] mid;

    assign ks        = ks_reg;
    assign last_half = {cfg.double_rounds, 1'b0} - 5'd1;

    // Build the starting words from key layout, nonce and counter.
    always_comb
    begin
        ka  = cfg.key_part_0;
        kb  = cfg.key_part_0;
        kc  = cfg.key_part_0;
        kd  = cfg.key_part_0;
        tau = s20_pkg::TAU3_08;
        mid = s20_pkg::MID_08;
        unique case (cfg.key_mode)
            s20_pkg::MODE_256:
            begin
                kb  = cfg.key_part_1;
                kc  = cfg.key_part_2;
                kd  = cfg.key_part_3;
                tau = s20_pkg::TAU3_32;
                mid = s20_pkg::MID_32;
            end
            s20_pkg::MODE_128:
            begin
                kb  = cfg.key_part_1;
                kd  = cfg.key_part_1;
                tau = s20_pkg::TAU3_16;
                mid = s20_pkg::MID_16;
            end
            default:
            begin
                tau = s20_pkg::TAU3_08;
                mid = s20_pkg::MID_08;
            end
        endcase
        s_init[0]  = s20_pkg::SIGMA0;
        s_init[1]  = ka[31:0];
        s_init[2]  = ka[63:32];
        s_init[3]  = kb[31:0];
        s_init[4]  = kb[63:32];
        s_init[5]  = tau;
        s_init[6]  = cfg.nonce_value[31:0];
        s_init[7]  = cfg.nonce_value[63:32];
        s_init[8]  = counter[31:0];
        s_init[9]  = counter[63:32];
        s_init[10] = mid;
        s_init[11] = kc[31:0];
        s_init[12] = kc[63:32];
        s_init[13] = kd[31:0];
        s_init[14] = kd[63:32];
        s_init[15] = s20_pkg::SIGMA3;
    end

    // Even steps mix columns, odd steps mix rows.
    always_comb
    begin
        if (half_reg[0])
            round_out = s20_pkg::row_round(work_reg);
        else
            round_out = s20_pkg::column_round(work_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            s20_pkg::CORE_IDLE:
                if (start)
                    state_next = (cfg.double_rounds == '0) ? s20_pkg::CORE_FINAL
                                                           : s20_pkg::CORE_ROUND;
            s20_pkg::CORE_ROUND:
                if (half_reg == last_half)
                    state_next = s20_pkg::CORE_FINAL;
            s20_pkg::CORE_FINAL:
                state_next = s20_pkg::CORE_IDLE;
            default:
                state_next = s20_pkg::CORE_IDLE;
        endcase
    end

    always_comb
    begin
        stat.busy = (state_reg != s20_pkg::CORE_IDLE);
        stat.done = (state_reg == s20_pkg::CORE_FINAL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= s20_pkg::CORE_IDLE;
            half_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == s20_pkg::CORE_IDLE)
                half_reg <= '0;
            else if (state_reg == s20_pkg::CORE_ROUND)
                half_reg <= half_reg + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == s20_pkg::CORE_IDLE && start)
        begin
            init_reg <= s_init;
            work_reg <= s_init;
        end
        else if (state_reg == s20_pkg::CORE_ROUND)
            work_reg <= round_out;
        if (state_reg == s20_pkg::CORE_FINAL)
        begin
            for (int k = 0; k < 16; k++)
                ks_reg[k] <= work_reg[k] + init_reg[k];
        end
    end

endmodule

@@ rtl/s20_back.sv @@
`include "assert_macros.svh"

module s20_back (
    input  logic              clk,
    input  logic              rst_n,
    input  s20_pkg::cfg_t     cfg,
    input  s20_pkg::q_stat_t  q_stat,
    input  s20_pkg::qentry_t  head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output s20_pkg::out_req_t out_req
);

    s20_pkg::core_stat_t stat;
    s20_pkg::state_t     ks;
    s20_pkg::out_req_t   out_reg;
    s20_pkg::out_req_t   out_next;

    logic         out_valid_reg;
    logic         ks_fresh_reg;
    logic         head_waits;
    logic         start;
    logic         slot_free;
    logic [511:0] ks_flat;
    logic [511:0] ks_shift;
    logic [63:0]  ks_lane;

    s20_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .start   (start),
        .counter (head.counter),
        .stat    (stat),
        .ks      (ks)
    );

    assign slot_free  = !out_valid_reg || !out_stall;
    assign head_waits = q_stat.nonempty && head.new_block && !ks_fresh_reg;
    assign start      = head_waits && !stat.busy;
    assign pop        = q_stat.nonempty && (!head.new_block || ks_fresh_reg) && slot_free;

    assign ks_flat  = ks;
    assign ks_shift = ks_flat >> {head.base, 3'b000};
    assign ks_lane  = ks_shift[63:0];

    // Keep bytes below the count, zero the rest.
    always_comb
    begin
        out_next.out_word  = '0;
        out_next.out_count = head.req.byte_count;
        out_next.out_last  = head.req.message_end;
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) < head.req.byte_count)
                out_next.out_word[8*i +: 8] = head.req.data_word[8*i +: 8] ^ ks_lane[8*i +: 8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            ks_fresh_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (stat.done)
                ks_fresh_reg <= 1'b1;
            else if (pop && head.new_block)
                ks_fresh_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_req   = out_reg;

    `ASSERT_IMPLIES(a_done_for_head, clk, rst_n, stat.done, head_waits)
    `ASSERT_IMPLIES(a_fresh_for_head, clk, rst_n, ks_fresh_reg, q_stat.nonempty && head.new_block)
    `ASSERT_IMPLIES(a_busy_holds_head, clk, rst_n, stat.busy, head_waits)

endmodule

@@ rtl/salsa20_stream_cipher.sv @@
// Channel   Handshake              Payload
// -------   --------------------   ------------------------------------------
// in        in_valid / in_stall    in_req  (data_word, byte_count, message_end)
// out       out_valid / out_stall  out_req (out_word, out_count, out_last)
// config    wr_en (no wait)        wr_index selects register, wr_data value
//
// A request that opens a keystream block waits at the queue head while the core
// runs one half round per cycle and adds in the starting words; any other request
// leaves in the cycle it reaches the head if the output register is free. The queue
// keeps accepting requests while the core hashes a block for its head request.
// Reset clears counter, lane offset, queue, core and output valid; config takes
// its reset values. in_stall rises only on a full queue; out_stall holds the output.

module salsa20_stream_cipher #(
    parameter int LANE_BYTES = s20_pkg::LANE_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  s20_pkg::in_req_t  in_req,
    output logic              out_valid,
    input  logic              out_stall,
    output s20_pkg::out_req_t out_req,
    input  logic              wr_en,
    input  logic [2:0]        wr_index,
    input  logic [63:0]       wr_data
);

    s20_pkg::cfg_t     cfg_reg;
    s20_pkg::q_stat_t  q_stat;
    s20_pkg::qentry_t  q_entry;
    s20_pkg::qentry_t  q_head;
    logic              q_push;
    logic              q_pop;

    // Configuration registers. Writes must come only while the datapath is idle;
    // the block does not enforce it, and the core reads them with no shadow copy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_part_0    <= '0;
            cfg_reg.key_part_1    <= '0;
            cfg_reg.key_part_2    <= '0;
            cfg_reg.key_part_3    <= '0;
            cfg_reg.nonce_value   <= '0;
            cfg_reg.key_mode      <= s20_pkg::MODE_256;
            cfg_reg.double_rounds <= s20_pkg::ROUNDS_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                s20_pkg::REG_KEY0:   cfg_reg.key_part_0    <= wr_data;
                s20_pkg::REG_KEY1:   cfg_reg.key_part_1    <= wr_data;
                s20_pkg::REG_KEY2:   cfg_reg.key_part_2    <= wr_data;
                s20_pkg::REG_KEY3:   cfg_reg.key_part_3    <= wr_data;
                s20_pkg::REG_NONCE:  cfg_reg.nonce_value   <= wr_data;
                s20_pkg::REG_MODE:   cfg_reg.key_mode      <= wr_data[1:0];
                s20_pkg::REG_ROUNDS: cfg_reg.double_rounds <= wr_data[3:0];
                default:             ; // drop writes to unmapped indexes
            endcase
        end
    end

    // Front end: saturate the count, tag block starts, track counter and lane.
    s20_front #(
        .LANE_BYTES (LANE_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_req   (in_req),
        .q_stat   (q_stat),
        .push     (q_push),
        .entry    (q_entry)
    );

    // Short queue decouples accept from keystream generation.
    s20_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .entry  (q_entry),
        .pop    (q_pop),
        .head   (q_head),
        .q_stat (q_stat)
    );

    // Back end: hash on block starts, XOR lanes, hold the result register.
    s20_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_stat    (q_stat),
        .head      (q_head),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_req   (out_req)
    );

endmodule

@@ dv/salsa20_lane_check.sv @@
module salsa20_lane_check (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  s20_pkg::in_req_t  in_req,
    input  logic              out_valid,
    input  logic              out_stall,
    input  s20_pkg::out_req_t out_req,
    input  logic              wr_en,
    input  logic [2:0]        wr_index,
    input  logic [63:0]       wr_data,
    output int                errors,
    output int                pending,
    output int                checked
);

    // Little-endian ASCII words of "expand NN-byte k".
    localparam logic [31:0] W_EXPA    = 32'h61707865;
    localparam logic [31:0] W_TE_K    = 32'h6b206574;
    localparam logic [31:0] W_ND3     = 32'h3320646e;
    localparam logic [31:0] W_ND1     = 32'h3120646e;
    localparam logic [31:0] W_ND0     = 32'h3020646e;
    localparam logic [31:0] W_BY2     = 32'h79622d32;
    localparam logic [31:0] W_BY6     = 32'h79622d36;
    localparam logic [31:0] W_BY8     = 32'h79622d38;

    s20_pkg::cfg_t     cfg_copy;
    logic [63:0]       blk_ctr;
    logic [2:0]        lane_idx;
    logic [511:0]      ks_block;
    s20_pkg::out_req_t predicted_q [$];
    int                err_n = 0;
    int                pend_n = 0;
    int                chk_n = 0;

    assign errors  = err_n;
    assign pending = pend_n;
    assign checked = chk_n;

    function automatic logic [31:0] rl(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic logic [127:0] mix4(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
        logic [31:0] na;
        logic [31:0] nb;
        logic [31:0] nc;
        logic [31:0] nd;
        nb = b ^ rl(a + d, 7);
        nc = c ^ rl(nb + a, 9);
        nd = d ^ rl(nc + nb, 13);
        na = a ^ rl(nd + nc, 18);
        return {na, nb, nc, nd};
    endfunction

    // Hash one 64-byte keystream block; word k lands in bits 32k+31:32k.
    function automatic logic [511:0] salsa_block(input s20_pkg::cfg_t c,
                                                 input logic [63:0] ctr);
        logic [31:0]  s [16];
        logic [31:0]  w [16];
        logic [63:0]  ka;
        logic [63:0]  kb;
        logic [63:0]  kc;
        logic [63:0]  kd;
        logic [511:0] ks;
        int           i;
        int           k;
        case (c.key_mode)
            s20_pkg::MODE_256:
            begin
                ka = c.key_part_0; kb = c.key_part_1;
                kc = c.key_part_2; kd = c.key_part_3;
                s[5] = W_ND3; s[10] = W_BY2;
            end
            s20_pkg::MODE_128:
            begin
                ka = c.key_part_0; kb = c.key_part_1;
                kc = c.key_part_0; kd = c.key_part_1;
                s[5] = W_ND1; s[10] = W_BY6;
            end
            default:
            begin
                // 64-bit layout, also taken by the spare mode code
                ka = c.key_part_0; kb = c.key_part_0;
                kc = c.key_part_0; kd = c.key_part_0;
                s[5] = W_ND0; s[10] = W_BY8;
            end
        endcase
        s[0]  = W_EXPA;      s[15] = W_TE_K;
        s[1]  = ka[31:0];    s[2]  = ka[63:32];
        s[3]  = kb[31:0];    s[4]  = kb[63:32];
        s[6]  = c.nonce_value[31:0];
        s[7]  = c.nonce_value[63:32];
        s[8]  = ctr[31:0];   s[9]  = ctr[63:32];
        s[11] = kc[31:0];    s[12] = kc[63:32];
        s[13] = kd[31:0];    s[14] = kd[63:32];
        for (k = 0; k < 16; k++)
            w[k] = s[k];
        for (i = 0; i < c.double_rounds; i++)
        begin
            {w[0],  w[4],  w[8],  w[12]} = mix4(w[0],  w[4],  w[8],  w[12]);
            {w[5],  w[9],  w[13], w[1]}  = mix4(w[5],  w[9],  w[13], w[1]);
            {w[10], w[14], w[2],  w[6]}  = mix4(w[10], w[14], w[2],  w[6]);
            {w[15], w[3],  w[7],  w[11]} = mix4(w[15], w[3],  w[7],  w[11]);
            {w[0],  w[1],  w[2],  w[3]}  = mix4(w[0],  w[1],  w[2],  w[3]);
            {w[5],  w[6],  w[7],  w[4]}  = mix4(w[5],  w[6],  w[7],  w[4]);
            {w[10], w[11], w[8],  w[9]}  = mix4(w[10], w[11], w[8],  w[9]);
            {w[15], w[12], w[13], w[14]} = mix4(w[15], w[12], w[13], w[14]);
        end
        for (k = 0; k < 16; k++)
            ks[32*k +: 32] = w[k] + s[k];
        return ks;
    endfunction

    // Work out the ciphered lane for one request and advance the stream.
    function automatic s20_pkg::out_req_t predict_lane(input s20_pkg::in_req_t r);
        s20_pkg::out_req_t o;
        logic [63:0]       lane;
        logic [3:0]        n;
        int                i;
        n = (r.byte_count > 4'd8) ? 4'd8 : r.byte_count;
        if (lane_idx == 3'd0)
        begin
            ks_block = salsa_block(cfg_copy, blk_ctr);
            blk_ctr  = blk_ctr + 64'd1;
        end
        lane = ks_block[64*lane_idx +: 64];
        o = '0;
        for (i = 0; i < 8; i++)
            if (i < n)
                o.out_word[8*i +: 8] = r.data_word[8*i +: 8] ^ lane[8*i +: 8];
        o.out_count = n;
        o.out_last  = r.message_end;
        lane_idx = lane_idx + 3'd1;
        if (r.message_end)
        begin
            blk_ctr  = '0;
            lane_idx = '0;
        end
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        s20_pkg::out_req_t want;
        if (!rst_n)
        begin
            cfg_copy = '0;
            cfg_copy.key_mode      = s20_pkg::MODE_256;
            cfg_copy.double_rounds = s20_pkg::ROUNDS_RESET;
            blk_ctr  = '0;
            lane_idx = '0;
            ks_block = '0;
            predicted_q.delete();
            pend_n = 0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    s20_pkg::REG_KEY0:   cfg_copy.key_part_0    = wr_data;
                    s20_pkg::REG_KEY1:   cfg_copy.key_part_1    = wr_data;
                    s20_pkg::REG_KEY2:   cfg_copy.key_part_2    = wr_data;
                    s20_pkg::REG_KEY3:   cfg_copy.key_part_3    = wr_data;
                    s20_pkg::REG_NONCE:  cfg_copy.nonce_value   = wr_data;
                    s20_pkg::REG_MODE:   cfg_copy.key_mode      = wr_data[1:0];
                    s20_pkg::REG_ROUNDS: cfg_copy.double_rounds = wr_data[3:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                predicted_q.push_back(predict_lane(in_req));
            if (out_valid && !out_stall)
            begin
                if (predicted_q.size() == 0)
                begin
                    err_n++;
                    $display("%0t: unexpected result, expected none, got %h", $time, out_req);
                end
                else
                begin
                    want = predicted_q.pop_front();
                    chk_n++;
                    if (out_req.out_word !== want.out_word)
                    begin
                        err_n++;
                        $display("%0t: out_word expected %h got %h",
                                 $time, want.out_word, out_req.out_word);
                    end
                    if (out_req.out_count !== want.out_count)
                    begin
                        err_n++;
                        $display("%0t: out_count expected %0d got %0d",
                                 $time, want.out_count, out_req.out_count);
                    end
                    if (out_req.out_last !== want.out_last)
                    begin
                        err_n++;
                        $display("%0t: out_last expected %0d got %0d",
                                 $time, want.out_last, out_req.out_last);
                    end
                end
            end
            pend_n = predicted_q.size();
        end
    end

endmodule

@@ dv/tb.sv @@
module tb;

    // Spare key mode code; the block treats it as the 64-bit layout.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // Receiver stall patterns, each held for a random stretch and then redrawn.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_mode_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    s20_pkg::in_req_t  in_req = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    s20_pkg::out_req_t out_req;
    logic              wr_en = 1'b0;
    logic [2:0]        wr_index = '0;
    logic [63:0]       wr_data = '0;

    int          err_count;
    int          pending_count;
    int          checked_count;

    int          burst_left = 0;
    int          sent_total = 0;
    int          msg_total = 0;
    int          settings_total = 0;

    rx_mode_t    rx_mode = RX_OPEN;
    int          rx_left = 0;
    int          rx_tick = 0;

    always #2 clk = ~clk;

    salsa20_stream_cipher u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_req   (out_req),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    // Watch both channels and the write port; predict and compare there.
    salsa20_lane_check u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_req   (out_req),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .errors    (err_count),
        .pending   (pending_count),
        .checked   (checked_count)
    );

    // Receiver: hold each pattern for a random stretch, then pick another.
    // The open pattern gives stretches with no stall at all; the periodic
    // one walks the stall across every phase of the block's work.
    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 1;
        if (rx_left == 0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(16, 96);
        end
        else
        begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:     out_stall <= 1'b0;
            RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: out_stall <= ((rx_tick % 5) < 2);
            default:     out_stall <= 1'b0;
        endcase
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic s20_pkg::in_req_t mk_req(input logic [63:0] d, input logic [3:0] n,
                                                input logic e);
        s20_pkg::in_req_t r;
        r.data_word   = d;
        r.byte_count  = n;
        r.message_end = e;
        return r;
    endfunction

    // Offer one request and hold it until accepted. Bursts of random length
    // alternate with random gaps; a zero gap keeps valid high across bursts.
    task automatic push_req(input s20_pkg::in_req_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 20);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_req   <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_total++;
        if (r.message_end)
            msg_total++;
    endtask

    // Drop valid and wait until every predicted result has come back.
    // The first edge lets the checker see the last accepted request.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [63:0] val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
    endtask

    // Write every register; junk above the mode and round fields must be
    // ignored by the block.
    task automatic load_settings(input logic [63:0] k0, input logic [63:0] k1,
                                 input logic [63:0] k2, input logic [63:0] k3,
                                 input logic [63:0] nv, input logic [1:0] mode,
                                 input logic [3:0] rounds);
        logic [63:0] junk;
        junk = rand64();
        put_reg(s20_pkg::REG_KEY0, k0);
        put_reg(s20_pkg::REG_KEY1, k1);
        put_reg(s20_pkg::REG_KEY2, k2);
        put_reg(s20_pkg::REG_KEY3, k3);
        put_reg(s20_pkg::REG_NONCE, nv);
        put_reg(s20_pkg::REG_MODE, {junk[63:2], mode});
        put_reg(s20_pkg::REG_ROUNDS, {junk[63:4], rounds});
        wr_en <= 1'b0;
        @(posedge clk);
        settings_total++;
    endtask

    // One message: full lanes with a final lane of random length. A broken
    // message carries random counts (zero and above eight included) and its
    // end mark may fall anywhere or not at all.
    task automatic send_message(input bit broken);
        int               len;
        int               i;
        s20_pkg::in_req_t r;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 10);
        for (i = 0; i < len; i++)
        begin
            r.data_word = rand64();
            if (broken)
            begin
                r.byte_count  = 4'($urandom_range(0, 15));
                r.message_end = (i == len - 1) ? 1'($urandom_range(0, 1))
                                               : ($urandom_range(0, 5) == 0);
            end
            else
            begin
                r.byte_count  = (i == len - 1) ? 4'($urandom_range(1, 8)) : 4'd8;
                r.message_end = (i == len - 1);
            end
            push_req(r);
        end
    endtask

    initial
    begin
        logic [63:0] k0;
        logic [63:0] k1;
        logic [63:0] k2;
        logic [63:0] k3;
        logic [63:0] nv;
        logic [1:0]  mode;
        logic [3:0]  rounds;
        int          ph;
        int          half;
        int          stop_at;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: 256-bit key of zeros, five double rounds. Run one
        // full keystream block of lanes and open the next one.
        push_req(mk_req(64'h0, 4'd8, 1'b0));
        push_req(mk_req({64{1'b1}}, 4'd8, 1'b0));
        push_req(mk_req({32{2'b01}}, 4'd8, 1'b0));
        push_req(mk_req(rand64(), 4'd0, 1'b0));     // zero count
        push_req(mk_req(rand64(), 4'd3, 1'b0));     // short lane, not the last
        push_req(mk_req(rand64(), 4'd15, 1'b0));    // count saturates
        push_req(mk_req(rand64(), 4'd9, 1'b0));
        push_req(mk_req({32{2'b10}}, 4'd8, 1'b0));
        push_req(mk_req(rand64(), 4'd8, 1'b0));     // second keystream block
        push_req(mk_req(rand64(), 4'd5, 1'b1));
        wait_idle();

        // Spare mode code with no rounds at all, every key bit set.
        load_settings({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}},
                      MODE_SPARE, 4'd0);
        push_req(mk_req(rand64(), 4'd8, 1'b0));
        push_req(mk_req(rand64(), 4'd8, 1'b1));
        push_req(mk_req(rand64(), 4'd1, 1'b1));     // single-request message
        wait_idle();

        load_settings(rand64(), rand64(), rand64(), rand64(), rand64(),
                      s20_pkg::MODE_64, 4'd15);
        push_req(mk_req(rand64(), 4'd8, 1'b0));
        push_req(mk_req(rand64(), 4'd8, 1'b0));
        push_req(mk_req(rand64(), 4'd7, 1'b1));
        wait_idle();

        load_settings(rand64(), rand64(), rand64(), rand64(), rand64(),
                      s20_pkg::MODE_128, 4'd1);
        push_req(mk_req(rand64(), 4'd8, 1'b0));
        push_req(mk_req(rand64(), 4'd2, 1'b1));
        push_req(mk_req({64{1'b1}}, 4'd8, 1'b1));
        wait_idle();

        // Standard Salsa20/20 over an all-zero key and nonce.
        load_settings(64'h0, 64'h0, 64'h0, 64'h0, 64'h0, s20_pkg::MODE_256, 4'd10);
        push_req(mk_req(64'h0, 4'd8, 1'b0));
        push_req(mk_req(64'h0, 4'd8, 1'b0));
        push_req(mk_req(rand64(), 4'd6, 1'b1));
        wait_idle();

        // Random phases: one setting each, mostly well-formed messages. Halt
        // the sender halfway through every phase until the results are in.
        for (ph = 0; ph < 6; ph++)
        begin
            k0 = rand64(); k1 = rand64(); k2 = rand64(); k3 = rand64();
            nv = rand64();
            case (ph)
                0: begin mode = s20_pkg::MODE_64;  rounds = 4'd1;  end
                1:
                begin
                    mode = s20_pkg::MODE_128; rounds = 4'd15;
                    k0 = '0; k1 = '0; k2 = '0; k3 = '0; nv = '0;
                end
                2: begin mode = s20_pkg::MODE_256; rounds = 4'd10; end
                3:
                begin
                    mode = MODE_SPARE; rounds = 4'd0;
                    k0 = '1; k1 = '1; k2 = '1; k3 = '1; nv = '1;
                end
                4:
                begin
                    mode   = s20_pkg::MODE_256;
                    rounds = 4'($urandom_range(1, 15));
                end
                default:
                begin
                    mode   = 2'($urandom_range(0, 3));
                    rounds = 4'($urandom_range(0, 15));
                end
            endcase
            load_settings(k0, k1, k2, k3, nv, mode, rounds);
            for (half = 0; half < 2; half++)
            begin
                stop_at = sent_total + 28;
                while (sent_total < stop_at)
                    send_message($urandom_range(0, 7) == 0);
                wait_idle();
            end
        end

        // Let any stray result surface before the verdict.
        repeat (40) @(posedge clk);
        $display("tb: %0d requests in %0d messages across %0d register settings",
                 sent_total, msg_total, settings_total);
        $display("tb: %0d results compared; key modes 0-3, 0 to 15 double rounds",
                 checked_count);
        if (err_count == 0 && pending_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // Hang guard: far beyond the slowest legal run.
    initial
    begin
        #1600000;
        $display("tb: done, errors");
        $finish;
    end

endmodule
